/* hdl/mms_pkg.sv */
package mms_pkg;

    typedef enum logic [2:0] {
        MODE_BOOT     = 3'd0,
        MODE_DETUMBLE = 3'd1,
        MODE_CHARGE   = 3'd2,
        MODE_OPTICAL  = 3'd3,
        MODE_RF       = 3'd4,
        MODE_RELAY    = 3'd5,
        MODE_STOREFWD = 3'd6,
        MODE_SAFE     = 3'd7
    } mode_t;

    typedef enum logic [3:0] {
        EV_BATCRIT   = 4'd0,
        EV_BATLOW    = 4'd1,
        EV_THERMCRIT = 4'd2,
        EV_TARGET    = 4'd3,
        EV_TXDONE    = 4'd4,
        EV_ALLSENT   = 4'd5,
        EV_FORCESAFE = 4'd6,
        EV_EXITSAFE  = 4'd7
    } event_code_t;

    typedef enum logic [2:0] {
        REG_BOOT_DELAY       = 3'd0,
        REG_DETUMBLE_LIMIT   = 3'd1,
        REG_DETUMBLE_TIMEOUT = 3'd2,
        REG_CHARGE_TO_SCAN   = 3'd3,
        REG_SCAN_TO_CHARGE   = 3'd4,
        REG_OPTICAL_SCAN     = 3'd5,
        REG_RF_SCAN          = 3'd6,
        REG_RELAY_TIMEOUT    = 3'd7
    } cfg_reg_idx_t;

    localparam logic       OP_EVENT  = 1'b0;
    localparam logic       OP_PERIOD = 1'b1;

    localparam logic [31:0] STOREFWD_HOLD_MS = 32'd5000;
    localparam logic [31:0] SAFE_HOLD_MS     = 32'd300000;

    // Settings seen by the mode logic
    typedef struct packed {
        logic [31:0] boot_delay_ms;
        logic [29:0] rate_limit_sq;
        logic [31:0] detumble_timeout_ms;
        logic [9:0]  charge_to_scan_level;
        logic [9:0]  scan_to_charge_level;
        logic [31:0] optical_scan_ms;
        logic [31:0] rf_scan_ms;
        logic [31:0] relay_timeout_ms;
    } cfg_t;

    // Registered input item, rates already squared
    typedef struct packed {
        logic        op;
        logic [3:0]  event_code;
        logic [31:0] now_ms;
        logic [9:0]  battery_level;
        logic [30:0] sq_x;
        logic [30:0] sq_y;
        logic [30:0] sq_z;
    } item_t;

    // Square of a signed Q4.12 rate; the most negative code gives 2^30
    function automatic logic [30:0] rate_sq(input logic [15:0] raw);
        logic [16:0] ext;
        logic [16:0] mag;
        logic [33:0] prod;
        ext  = {raw[15], raw};
        mag  = ext[16] ? (17'd0 - ext) : ext;
        prod = mag * mag;
        return prod[30:0];
    endfunction

endpackage

/* hdl/mms_cfg.sv */
module mms_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output mms_pkg::cfg_t       cfg
);

    logic [31:0] boot_delay_reg;
    logic [14:0] rate_limit_reg;
    logic [29:0] rate_limit_sq_reg;
    logic [31:0] detumble_timeout_reg;
    logic [9:0]  charge_to_scan_reg;
    logic [9:0]  scan_to_charge_reg;
    logic [31:0] optical_scan_reg;
    logic [31:0] rf_scan_reg;
    logic [31:0] relay_timeout_reg;
    logic [29:0] rate_limit_sq_next;

    assign cfg_ready = 1'b1;

    // Square of the limit, registered in the cycle after the write
    assign rate_limit_sq_next = rate_limit_reg * rate_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_delay_reg       <= 32'd5000;
            rate_limit_reg       <= 15'd410;
            rate_limit_sq_reg    <= 30'd168100;
            detumble_timeout_reg <= 32'd600000;
            charge_to_scan_reg   <= 10'd800;
            scan_to_charge_reg   <= 10'd400;
            optical_scan_reg     <= 32'd60000;
            rf_scan_reg          <= 32'd60000;
            relay_timeout_reg    <= 32'd120000;
        end else begin
            rate_limit_sq_reg <= rate_limit_sq_next;
            if (cfg_valid) begin
                case (mms_pkg::cfg_reg_idx_t'(cfg_index))
                    mms_pkg::REG_BOOT_DELAY:       boot_delay_reg       <= cfg_data;
                    mms_pkg::REG_DETUMBLE_LIMIT:   rate_limit_reg       <= cfg_data[14:0];
                    mms_pkg::REG_DETUMBLE_TIMEOUT: detumble_timeout_reg <= cfg_data;
                    mms_pkg::REG_CHARGE_TO_SCAN:   charge_to_scan_reg   <= cfg_data[9:0];
                    mms_pkg::REG_SCAN_TO_CHARGE:   scan_to_charge_reg   <= cfg_data[9:0];
                    mms_pkg::REG_OPTICAL_SCAN:     optical_scan_reg     <= cfg_data;
                    mms_pkg::REG_RF_SCAN:          rf_scan_reg          <= cfg_data;
                    mms_pkg::REG_RELAY_TIMEOUT:    relay_timeout_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        cfg.boot_delay_ms        = boot_delay_reg;
        cfg.rate_limit_sq        = rate_limit_sq_reg;
        cfg.detumble_timeout_ms  = detumble_timeout_reg;
        cfg.charge_to_scan_level = charge_to_scan_reg;
        cfg.scan_to_charge_level = scan_to_charge_reg;
        cfg.optical_scan_ms      = optical_scan_reg;
        cfg.rf_scan_ms           = rf_scan_reg;
        cfg.relay_timeout_ms     = relay_timeout_reg;
    end

endmodule

/* hdl/mms_in.sv */
module mms_in (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [95:0]         s_tdata,
    input  logic [0:0]          s_tuser,
    output logic                item_valid,
    input  logic                item_take,
    output mms_pkg::item_t      item
);

    logic           valid_reg;
    mms_pkg::item_t item_reg;
    mms_pkg::item_t item_next;
    logic           load;

    assign s_tready = !valid_reg || item_take;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        item_next.op            = s_tuser[0];
        item_next.event_code    = s_tdata[3:0];
        item_next.now_ms        = s_tdata[35:4];
        item_next.sq_x          = mms_pkg::rate_sq(s_tdata[51:36]);
        item_next.sq_y          = mms_pkg::rate_sq(s_tdata[67:52]);
        item_next.sq_z          = mms_pkg::rate_sq(s_tdata[83:68]);
        item_next.battery_level = s_tdata[93:84];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/mms_core.sv */
module mms_core #(
    parameter int SAFE_EXIT_LEVEL = 500
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mms_pkg::cfg_t       cfg,
    input  logic                item_valid,
    output logic                item_take,
    input  mms_pkg::item_t      item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata
);

    localparam logic [9:0] SAFE_EXIT = 10'(SAFE_EXIT_LEVEL);

    mms_pkg::mode_t current_reg, current_next;
    mms_pkg::mode_t pending_reg, pending_next;
    logic [31:0]    entry_reg, entry_next;
    logic           parity_reg, parity_next;
    logic           target_reg, target_next;
    logic           relay_reg, relay_next;
    logic           out_valid_reg;
    logic [7:0]     out_data_reg;

    logic [31:0]    elapsed;
    logic [31:0]    rate_sum;
    logic [31:0]    scan_limit;
    logic           changed, emergency, ready;

    assign item_take = !out_valid_reg || m_tready;

    assign elapsed    = item.now_ms - entry_reg;
    assign rate_sum   = 32'(item.sq_x) + 32'(item.sq_y) + 32'(item.sq_z);
    assign scan_limit = (current_reg == mms_pkg::MODE_OPTICAL) ? cfg.optical_scan_ms
                                                             : cfg.rf_scan_ms;

    always_comb begin
        current_next = current_reg;
        pending_next = pending_reg;
        entry_next   = entry_reg;
        parity_next  = parity_reg;
        target_next  = target_reg;
        relay_next   = relay_reg;
        changed      = 1'b0;
        emergency    = 1'b0;
        ready        = 1'b0;

        if (item.op == mms_pkg::OP_EVENT) begin
            case (mms_pkg::event_code_t'(item.event_code))
                mms_pkg::EV_BATCRIT,
                mms_pkg::EV_FORCESAFE: pending_next = mms_pkg::MODE_SAFE;
                mms_pkg::EV_BATLOW: begin
                    if (current_reg != mms_pkg::MODE_SAFE) begin
                        pending_next = mms_pkg::MODE_CHARGE;
                    end
                end
                mms_pkg::EV_THERMCRIT,
                mms_pkg::EV_EXITSAFE: pending_next = mms_pkg::MODE_CHARGE;
                mms_pkg::EV_TARGET: target_next = 1'b1;
                mms_pkg::EV_TXDONE,
                mms_pkg::EV_ALLSENT: relay_next = 1'b1;
                default: ;
            endcase
        end else begin
            case (current_reg)
                mms_pkg::MODE_BOOT: begin
                    if (elapsed >= cfg.boot_delay_ms) begin
                        pending_next = mms_pkg::MODE_DETUMBLE;
                    end
                end
                mms_pkg::MODE_DETUMBLE: begin
                    if (rate_sum < 32'(cfg.rate_limit_sq)
                            || elapsed >= cfg.detumble_timeout_ms) begin
                        pending_next = mms_pkg::MODE_CHARGE;
                    end
                end
                mms_pkg::MODE_CHARGE: begin
                    if (item.battery_level >= cfg.charge_to_scan_level) begin
                        ready        = 1'b1;
                        pending_next = parity_reg ? mms_pkg::MODE_RF : mms_pkg::MODE_OPTICAL;
                        parity_next  = !parity_reg;
                    end
                end
                mms_pkg::MODE_OPTICAL,
                mms_pkg::MODE_RF: begin
                    if (target_reg) begin
                        target_next  = 1'b0;
                        pending_next = mms_pkg::MODE_RELAY;
                    end else if (elapsed >= scan_limit
                            || item.battery_level <= cfg.scan_to_charge_level) begin
                        pending_next = mms_pkg::MODE_CHARGE;
                    end
                end
                mms_pkg::MODE_RELAY: begin
                    if (relay_reg) begin
                        relay_next   = 1'b0;
                        pending_next = mms_pkg::MODE_CHARGE;
                    end else if (elapsed >= cfg.relay_timeout_ms) begin
                        pending_next = mms_pkg::MODE_STOREFWD;
                    end
                end
                mms_pkg::MODE_STOREFWD: begin
                    if (elapsed >= mms_pkg::STOREFWD_HOLD_MS) begin
                        pending_next = mms_pkg::MODE_CHARGE;
                    end
                end
                default: begin
                    if (item.battery_level >= SAFE_EXIT
                            && elapsed >= mms_pkg::SAFE_HOLD_MS) begin
                        pending_next = mms_pkg::MODE_CHARGE;
                    end
                end
            endcase

            // Switch when the pending mode differs, and restart the mode clock
            if (pending_next != current_reg) begin
                current_next = pending_next;
                entry_next   = item.now_ms;
                changed      = 1'b1;
                emergency    = (pending_next == mms_pkg::MODE_SAFE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_reg   <= mms_pkg::MODE_BOOT;
            pending_reg   <= mms_pkg::MODE_BOOT;
            entry_reg     <= 32'd0;
            parity_reg    <= 1'b0;
            target_reg    <= 1'b0;
            relay_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (item_take) begin
                out_valid_reg <= item_valid;
            end
            if (item_valid && item_take) begin
                current_reg <= current_next;
                pending_reg <= pending_next;
                entry_reg   <= entry_next;
                parity_reg  <= parity_next;
                target_reg  <= target_next;
                relay_reg   <= relay_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid && item_take) begin
            out_data_reg <= {2'b00, ready, emergency, changed, current_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hdl/mission_mode_sequencer.sv */
// Channel  | Direction | Handshake          | Contents
// s_       | in        | s_tvalid/s_tready  | tuser: op; tdata: event and period fields
// m_       | out       | m_tvalid/m_tready  | tdata: mode and status flags
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index selects register, cfg_data value
//
// Every item gives one result: the item waits in the input register (rates squared on
// the way in) while the mode logic works on it, and the result register loads as the
// item is taken. One item is accepted per cycle unless the result side stalls; the mode
// state updates as each item is taken. Synchronous active-low reset puts all settings to
// their defaults and the sequencer into boot. A stalled result holds the result register,
// and the input register refills behind it, so ready drops only when both are full.
module mission_mode_sequencer #(
    parameter int SAFE_EXIT_LEVEL = 500
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] event_code, [35:4] now_ms, [51:36] rate_x, [67:52] rate_y,
    // [83:68] rate_z, [93:84] battery_level, [95:94] zero
    input  logic [95:0] s_tdata,
    // [0] op
    input  logic [0:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] mode, [3] mode_changed, [4] emergency_shutdown, [5] charge_ready,
    // [7:6] zero
    output logic [7:0]  m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    mms_pkg::cfg_t  cfg;
    mms_pkg::item_t item;
    logic           item_valid;
    logic           item_take;

    // Settings registers; the squared rate limit follows in the cycle after a write
    mms_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Hold the accepted item and its squared rates
    mms_in u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    // Advance the mode state and register the result
    mms_core #(
        .SAFE_EXIT_LEVEL (SAFE_EXIT_LEVEL)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* verif/mms_mode_audit.sv */
module mms_mode_audit #(
    parameter int SAFE_EXIT = 500
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          mismatches,
    output int          outstanding,
    output int          items_in,
    output int          events_in,
    output int          results_out,
    output int          switches,
    output int          readies,
    output logic [7:0]  modes_hit
);
    timeunit 1ns;
    timeprecision 1ps;
    import mms_pkg::*;

    typedef struct packed {
        mode_t mode;
        logic  changed;
        logic  emergency;
        logic  ready;
    } status_t;

    status_t due_status_q[$];
    status_t want;

    // settings as the block should hold them
    logic [31:0] boot_delay;
    logic [14:0] rate_limit;
    logic [31:0] detumble_timeout;
    logic [9:0]  scan_start_level;
    logic [9:0]  scan_abort_level;
    logic [31:0] optical_limit;
    logic [31:0] rf_limit;
    logic [31:0] relay_limit;

    // sequencer state
    mode_t       cur_mode;
    mode_t       next_mode;
    logic [31:0] entered_ms;
    logic        rf_next;
    logic        target_flag;
    logic        relay_flag;

    function automatic longint unsigned square_rate(input logic [15:0] raw);
        int v;
        v = $signed(raw);
        return v * v;
    endfunction

    function automatic void scan_check(input logic [31:0] elapsed, input logic [31:0] limit,
                                       input logic [9:0] bat);
        if (target_flag) begin
            target_flag = 1'b0;
            next_mode   = MODE_RELAY;
        end else if (elapsed >= limit) begin
            next_mode = MODE_CHARGE;
        end else if (bat <= scan_abort_level) begin
            next_mode = MODE_CHARGE;
        end
    endfunction

    // Advance the sequencer by one item and return the status it should report
    function automatic status_t sequence_step(input logic op, input logic [3:0] code,
                                              input logic [31:0] now, input logic [15:0] rx,
                                              input logic [15:0] ry, input logic [15:0] rz,
                                              input logic [9:0] bat);
        status_t         st;
        logic [31:0]     elapsed;
        longint unsigned spin;
        longint unsigned lim_sq;
        st = '0;
        if (op == OP_EVENT) begin
            case (code)
                EV_BATCRIT, EV_FORCESAFE: next_mode = MODE_SAFE;
                EV_BATLOW:                if (cur_mode != MODE_SAFE) next_mode = MODE_CHARGE;
                EV_THERMCRIT, EV_EXITSAFE: next_mode = MODE_CHARGE;
                EV_TARGET:                target_flag = 1'b1;
                EV_TXDONE, EV_ALLSENT:    relay_flag = 1'b1;
                default: ;
            endcase
        end else begin
            elapsed = now - entered_ms;
            case (cur_mode)
                MODE_BOOT: if (elapsed >= boot_delay) next_mode = MODE_DETUMBLE;
                MODE_DETUMBLE: begin
                    spin   = square_rate(rx) + square_rate(ry) + square_rate(rz);
                    lim_sq = longint'(rate_limit) * longint'(rate_limit);
                    if (spin < lim_sq || elapsed >= detumble_timeout) next_mode = MODE_CHARGE;
                end
                MODE_CHARGE: begin
                    if (bat >= scan_start_level) begin
                        st.ready  = 1'b1;
                        next_mode = rf_next ? MODE_RF : MODE_OPTICAL;
                        rf_next   = ~rf_next;
                    end
                end
                MODE_OPTICAL: scan_check(elapsed, optical_limit, bat);
                MODE_RF:      scan_check(elapsed, rf_limit, bat);
                MODE_RELAY: begin
                    if (relay_flag) begin
                        relay_flag = 1'b0;
                        next_mode  = MODE_CHARGE;
                    end else if (elapsed >= relay_limit) begin
                        next_mode = MODE_STOREFWD;
                    end
                end
                MODE_STOREFWD: if (elapsed >= STOREFWD_HOLD_MS) next_mode = MODE_CHARGE;
                MODE_SAFE: begin
                    if (int'(bat) >= SAFE_EXIT && elapsed >= SAFE_HOLD_MS) next_mode = MODE_CHARGE;
                end
            endcase
            if (next_mode != cur_mode) begin
                cur_mode     = next_mode;
                entered_ms   = now;
                st.changed   = 1'b1;
                st.emergency = (next_mode == MODE_SAFE);
            end
        end
        st.mode = cur_mode;
        return st;
    endfunction

    function automatic void apply_setting(input logic [2:0] idx, input logic [31:0] val);
        case (cfg_reg_idx_t'(idx))
            REG_BOOT_DELAY:       boot_delay       = val;
            REG_DETUMBLE_LIMIT:   rate_limit       = val[14:0];
            REG_DETUMBLE_TIMEOUT: detumble_timeout = val;
            REG_CHARGE_TO_SCAN:   scan_start_level = val[9:0];
            REG_SCAN_TO_CHARGE:   scan_abort_level = val[9:0];
            REG_OPTICAL_SCAN:     optical_limit    = val;
            REG_RF_SCAN:          rf_limit         = val;
            REG_RELAY_TIMEOUT:    relay_limit      = val;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < 40) $display("%0t ns: result %0d mismatch, %s", $time, results_out, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            boot_delay       = 32'd5000;
            rate_limit       = 15'd410;
            detumble_timeout = 32'd600000;
            scan_start_level = 10'd800;
            scan_abort_level = 10'd400;
            optical_limit    = 32'd60000;
            rf_limit         = 32'd60000;
            relay_limit      = 32'd120000;
            cur_mode         = MODE_BOOT;
            next_mode        = MODE_BOOT;
            entered_ms       = '0;
            rf_next          = 1'b0;
            target_flag      = 1'b0;
            relay_flag       = 1'b0;
            due_status_q.delete();
            mismatches  = 0;
            outstanding = 0;
            items_in    = 0;
            events_in   = 0;
            results_out = 0;
            switches    = 0;
            readies     = 0;
            modes_hit   = '0;
        end else begin
            if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);

            if (m_tvalid && m_tready) begin
                if (due_status_q.size() == 0) begin
                    flag_mismatch($sformatf("tdata %h arrived with nothing due", m_tdata));
                end else begin
                    want = due_status_q.pop_front();
                    if (m_tdata[2:0] !== want.mode)
                        flag_mismatch($sformatf("mode %0d, want %0d", m_tdata[2:0], want.mode));
                    if (m_tdata[3] !== want.changed)
                        flag_mismatch($sformatf("mode_changed %b, want %b",
                                                m_tdata[3], want.changed));
                    if (m_tdata[4] !== want.emergency)
                        flag_mismatch($sformatf("emergency_shutdown %b, want %b",
                                                m_tdata[4], want.emergency));
                    if (m_tdata[5] !== want.ready)
                        flag_mismatch($sformatf("charge_ready %b, want %b",
                                                m_tdata[5], want.ready));
                end
                results_out++;
            end

            if (s_tvalid && s_tready) begin
                want = sequence_step(s_tuser[0], s_tdata[3:0], s_tdata[35:4], s_tdata[51:36],
                                     s_tdata[67:52], s_tdata[83:68], s_tdata[93:84]);
                due_status_q.push_back(want);
                items_in++;
                if (s_tuser[0] == OP_EVENT) events_in++;
                if (want.changed) switches++;
                if (want.ready) readies++;
                modes_hit[want.mode] = 1'b1;
            end

            outstanding = due_status_q.size();
        end
    end

endmodule

/* verif/mission_mode_sequencer_test.sv */
module mission_mode_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mms_pkg::*;

    localparam int          SAFE_EXIT      = 500;
    localparam int          CYCLE_LIMIT    = 600000;  // many times the slowest honest run
    localparam int          SQUEEZE_CYCLES = 100;     // receiver hold-off for the pressure test
    localparam logic [3:0]  EV_UNKNOWN     = 4'd15;   // beyond the last defined event code

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;     // [3:0] event_code, [35:4] now_ms, [51:36] rate_x,
                              // [67:52] rate_y, [83:68] rate_z, [93:84] battery_level
    logic [0:0]  s_tuser;     // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // [2:0] mode, [3] mode_changed, [4] emergency_shutdown,
                              // [5] charge_ready
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // handshakes as seen at the last rising edge
    logic        s_took;
    logic        cfg_took;

    int          mismatches;
    int          outstanding;
    int          items_in;
    int          events_in;
    int          results_out;
    int          switches;
    int          readies;
    logic [7:0]  modes_hit;

    int          cycles;
    int          writes;
    int          squeeze_req;
    int          squeeze_done;
    bit          squeezing;
    bit          calm;          // no idling on either side while set
    logic [31:0] clock_ms;      // spacecraft time carried by period items

    mission_mode_sequencer #(.SAFE_EXIT_LEVEL(SAFE_EXIT)) DUT (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    mms_mode_audit #(.SAFE_EXIT(SAFE_EXIT)) mode_audit (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .mismatches, .outstanding, .items_in, .events_in, .results_out,
        .switches, .readies, .modes_hit
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Record handshakes at the rising edge; the stimulus reads them at the falling edge
    always @(posedge aclk) begin
        s_took   <= s_tvalid && s_tready;
        cfg_took <= cfg_valid && cfg_ready;
    end

    // Watchdog: give up if the run hangs anywhere
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random ready bursts and stalls, plus one long hold-off on request
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            if (squeeze_req != squeeze_done) begin
                m_tready  = 1'b0;
                squeezing = 1'b1;
                repeat (SQUEEZE_CYCLES) @(negedge aclk);
                squeezing = 1'b0;
                squeeze_done++;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
            end else begin
                m_tready = 1'b0;
                repeat (idle_len()) @(negedge aclk);
            end
        end
    end

    // Offer one item and hold it until taken, then maybe leave a gap
    task automatic offer_item(input logic op, input logic [3:0] code, input logic [31:0] now,
                              input logic [15:0] rx, input logic [15:0] ry,
                              input logic [15:0] rz, input logic [9:0] bat);
        int gap;
        s_tuser  = op;
        s_tdata  = {2'b00, bat, rz, ry, rx, now, code};
        s_tvalid = 1'b1;
        do @(negedge aclk); while (!s_took);
        gap = calm ? 0 : (($urandom_range(0, 99) < 60) ? 0 : idle_len());
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Events carry junk in the period fields; it must be ignored
    task automatic send_event(input logic [3:0] code);
        offer_item(OP_EVENT, code, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                   10'($urandom));
    endtask

    task automatic send_period(input logic [31:0] now, input logic [9:0] bat,
                               input logic [15:0] rx, input logic [15:0] ry,
                               input logic [15:0] rz);
        offer_item(OP_PERIOD, 4'($urandom), now, rx, ry, rz, bat);
    endtask

    // Drop valid and wait until every result is home and the pipeline is empty
    task automatic settle();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_idx_t idx, input logic [31:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(negedge aclk); while (!cfg_took);
        cfg_valid = 1'b0;
        writes++;
    endtask

    task automatic load_settings(input logic [31:0] boot, input logic [31:0] rate_lim,
                                 input logic [31:0] det_to, input logic [31:0] up_lvl,
                                 input logic [31:0] down_lvl, input logic [31:0] opt_ms,
                                 input logic [31:0] rf_ms, input logic [31:0] relay_ms);
        settle();
        write_reg(REG_BOOT_DELAY, boot);
        write_reg(REG_DETUMBLE_LIMIT, rate_lim);
        write_reg(REG_DETUMBLE_TIMEOUT, det_to);
        write_reg(REG_CHARGE_TO_SCAN, up_lvl);
        write_reg(REG_SCAN_TO_CHARGE, down_lvl);
        write_reg(REG_OPTICAL_SCAN, opt_ms);
        write_reg(REG_RF_SCAN, rf_ms);
        write_reg(REG_RELAY_TIMEOUT, relay_ms);
    endtask

    // Weight the events so that the mode cycle keeps turning: targets and relay
    // completions often, the safe-mode triggers seldom
    function automatic logic [3:0] pick_event();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)  return EV_BATCRIT;
        if (r < 8)  return EV_FORCESAFE;
        if (r < 14) return EV_EXITSAFE;
        if (r < 24) return EV_BATLOW;
        if (r < 30) return EV_THERMCRIT;
        if (r < 58) return EV_TARGET;
        if (r < 72) return EV_TXDONE;
        if (r < 86) return EV_ALLSENT;
        return 4'($urandom_range(8, 15));
    endfunction

    // Small rates let detumble finish; extremes and noise the rest of the time
    function automatic logic [15:0] pick_rate();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(0, 600)) - 16'd300;
        if (r < 60) begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [9:0] pick_battery();
        case ($urandom_range(0, 9))
            0:       return 10'd0;
            1:       return 10'd1023;
            2:       return 10'd500;
            3:       return 10'd499;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // Time advance: mostly within the phase's span, sometimes far enough to
    // leave safe mode, rarely anywhere (which looks like time running backwards)
    function automatic logic [31:0] time_step(input int unsigned span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, span);
        if (r < 85) return $urandom_range(0, 4 * span);
        if (r < 97) return $urandom_range(250000, 400000);
        return $urandom;
    endfunction

    task automatic random_items(input int unsigned span, input int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 35) begin
                send_event(pick_event());
            end else begin
                clock_ms = clock_ms + time_step(span);
                send_period(clock_ms, pick_battery(), pick_rate(), pick_rate(), pick_rate());
            end
        end
    endtask

    initial begin : stimulus
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = '0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_BOOT_DELAY;
        cfg_data  = '0;
        clock_ms  = '0;
        writes    = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed walk through every mode at the reset settings
        send_period(32'd0, 10'd500, 16'd0, 16'd0, 16'd0);          // boot: too early
        send_period(32'd5000, 10'd500, 16'd0, 16'd0, 16'd0);       // boot -> detumble
        send_period(32'd5000, 10'd500, 16'h8000, 16'h7FFF, 16'h8000); // tumbling hard
        send_period(32'd5001, 10'd500, 16'd410, 16'd0, 16'd0);     // magnitude on the limit
        send_period(32'd5002, 10'd500, 16'd0, 16'd0, 16'hFE67);    // -409: -> charge
        send_event(EV_UNKNOWN);                                    // ignored
        send_event(EV_FORCESAFE);                                  // pending safe ...
        send_period(32'd5003, 10'd800, 16'd0, 16'd0, 16'd0);       // ... overridden: optical
        send_event(EV_TARGET);
        send_period(32'd5004, 10'd0, 16'd0, 16'd0, 16'd0);         // target beats flat battery
        send_event(EV_ALLSENT);
        send_period(32'd5005, 10'd500, 16'd0, 16'd0, 16'd0);       // relay done -> charge
        send_period(32'd5006, 10'd1023, 16'd0, 16'd0, 16'd0);      // RF this time round
        send_period(32'd5007, 10'd400, 16'd0, 16'd0, 16'd0);       // battery on abort level
        send_period(32'd5008, 10'd1000, 16'd0, 16'd0, 16'd0);      // optical again
        send_period(32'd65008, 10'd1000, 16'd0, 16'd0, 16'd0);     // scan time up
        send_period(32'd65009, 10'd900, 16'd0, 16'd0, 16'd0);      // RF
        send_event(EV_TARGET);
        send_period(32'd65010, 10'd900, 16'd0, 16'd0, 16'd0);      // -> relay
        send_period(32'd185010, 10'd900, 16'd0, 16'd0, 16'd0);     // relay timed out
        send_period(32'd190010, 10'd700, 16'd0, 16'd0, 16'd0);     // store-forward hold over
        send_event(EV_BATCRIT);
        send_period(32'd190011, 10'd0, 16'd0, 16'd0, 16'd0);       // -> safe, emergency
        send_event(EV_BATLOW);                                     // no effect in safe
        send_period(32'd490011, 10'd499, 16'd0, 16'd0, 16'd0);     // hold met, battery short
        send_period(32'd490011, 10'd500, 16'd0, 16'd0, 16'd0);     // -> charge
        send_event(EV_TXDONE);                                     // flag kept for later
        send_event(EV_THERMCRIT);
        send_event(EV_FORCESAFE);
        send_period(32'd490012, 10'd100, 16'd0, 16'd0, 16'd0);     // -> safe
        send_event(EV_EXITSAFE);
        send_period(32'd490013, 10'd100, 16'd0, 16'd0, 16'd0);     // -> charge
        clock_ms = 32'd490013;

        // Brisk timings so the cycle turns over quickly; open with the pressure test:
        // hold the result side off and keep offering until the input stalls
        load_settings(32'd16, 32'd3000, 32'd300, 32'd600, 32'd300, 32'd200, 32'd150, 32'd250);
        squeeze_req++;
        while (!squeezing) @(negedge aclk);
        calm = 1'b1;
        random_items(60, 30);
        calm = 1'b0;
        random_items(60, 130);

        // Every setting at its minimum
        load_settings('0, '0, '0, '0, '0, '0, '0, '0);
        random_items(20, 100);

        // Every setting at its maximum; narrow registers keep only their low bits
        load_settings('1, '1, '1, '1, '1, '1, '1, '1);
        random_items(2000, 100);

        // Random settings, wide values into the narrow registers
        load_settings($urandom_range(0, 300), $urandom, $urandom_range(0, 2000), $urandom,
                      $urandom, $urandom_range(0, 3000), $urandom_range(0, 3000),
                      $urandom_range(0, 3000));
        random_items(1000, 130);

        // Carry the clock across the 32-bit wrap, with no idling on either side
        load_settings(32'd16, 32'd3000, 32'd300, 32'd600, 32'd300, 32'd200, 32'd150, 32'd250);
        clock_ms = 32'hFFFF_FF00;
        calm = 1'b1;
        random_items(40, 120);
        calm = 1'b0;

        // Back to the reset values with coarse time steps
        load_settings(32'd5000, 32'd410, 32'd600000, 32'd800, 32'd400, 32'd60000, 32'd60000,
                      32'd120000);
        random_items(30000, 150);

        // Drain, then keep the clock running to catch any stray result
        settle();
        repeat (6) @(negedge aclk);

        $display("covered %0d items (%0d events), %0d results checked, %0d mode switches,",
                 items_in, events_in, results_out, switches);
        $display("%0d charge-ready steps, modes entered %08b (safe..boot), %0d register writes",
                 readies, modes_hit, writes);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
